FILE: hdl/ogl_pkg.sv
// shared constants, codes and types of the occupancy grid line-of-sight core
package ogl_pkg;

   // grid geometry
   localparam int MAX_SIDE = 64;
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W   = COORD_W + 1;
   localparam int ADDR_W   = 2 * COORD_W;
   localparam int CELLS    = MAX_SIDE * MAX_SIDE;
   // crossing products reach (2*MAX_SIDE-1)*(MAX_SIDE-1)
   localparam int LHS_W    = ADDR_W + 1;

   // port field widths
   localparam int CFG_W     = 7;
   localparam int FIELD_W   = 8;
   localparam int STATUS_W  = 2;
   localparam int HIT_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CMP_W     = FIELD_W + 2;

   // register reset value
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_LENGTH = 2'd1
   } csr_index_type;

   typedef enum logic {
      ACTION_PAINT = 1'b0,
      ACTION_LINE  = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVERTED = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_REPORT = 2'd0,
      CMD_PAINT  = 2'd1,
      CMD_LINE   = 2'd2
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'd0,
      ST_IDLE  = 3'd1,
      ST_PAINT = 3'd2,
      ST_LINE  = 3'd3,
      ST_FLUSH = 3'd4,
      ST_DONE  = 3'd5
   } back_state_type;

   // classified work item handed from front to back
   typedef struct packed {
      cmd_kind_type        kind;
      status_type          status;
      logic [COORD_W-1:0]  x_lo;
      logic [COORD_W-1:0]  x_hi;
      logic [COORD_W-1:0]  y_lo;
      logic [COORD_W-1:0]  y_hi;
      logic [COORD_W-1:0]  nx;
      logic [COORD_W-1:0]  ny;
      logic                x_neg;
      logic                y_neg;
      logic [ADDR_W-1:0]   addr;
      logic [SIDE_W-1:0]   len;
   } cmd_type;

endpackage

FILE: hdl/ogl_ram.sv
// generic single-write, single-read ram with registered read data
module ogl_ram #(
   parameter int  WIDTH = 1,
   parameter int  DEPTH = 4096,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ogl_queue.sv
// short command queue that decouples the classifier from the executor
module ogl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ogl_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output ogl_pkg::cmd_type head_cmd
);

   import ogl_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

endmodule

FILE: hdl/ogl_front.sv
// front end: configuration registers, request intake and classification
module ogl_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic signed [ogl_pkg::FIELD_W-1:0] req_first_x,
   input  logic signed [ogl_pkg::FIELD_W-1:0] req_first_y,
   input  logic signed [ogl_pkg::FIELD_W-1:0] req_second_x,
   input  logic signed [ogl_pkg::FIELD_W-1:0] req_second_y,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ogl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ogl_pkg::CFG_W-1:0]        csr_data,
   input  logic                             q_full,
   input  logic                             clearing,
   output logic                             q_push,
   output ogl_pkg::cmd_type                 q_cmd
);

   import ogl_pkg::*;

   logic [CFG_W-1:0]       grid_width_ff, grid_width_in;
   logic [CFG_W-1:0]       grid_length_ff, grid_length_in;
   logic [SIDE_W-1:0]      width_eff, length_eff;
   logic signed [CMP_W-1:0] ax, ay, bx, by;
   logic signed [CMP_W-1:0] x_max, y_max;
   logic signed [CMP_W-1:0] x0, x1, y0, y1;
   logic signed [CMP_W-1:0] dx, dy, adx, ady;
   logic                   outside;
   logic [ADDR_W:0]        base_prod;
   cmd_type                cmd;

   // zero counts as one, anything above the grid side as the side
   function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] r);
      logic [SIDE_W-1:0] s;
      if (r == '0) begin
         s = SIDE_W'(1);
      end else if (int'(r) > MAX_SIDE) begin
         s = SIDE_W'(MAX_SIDE);
      end else begin
         s = SIDE_W'(r);
      end
      return s;
   endfunction

   // configuration register writes
   assign csr_ready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_length_in = grid_length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_data;
            CSR_GRID_LENGTH: grid_length_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= CFG_RESET;
         grid_length_ff <= CFG_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_length_ff <= grid_length_in;
      end
   end

   assign width_eff  = eff_side(grid_width_ff);
   assign length_eff = eff_side(grid_length_ff);

   // corner arithmetic in signed form
   always_comb begin
      ax      = CMP_W'(req_first_x);
      ay      = CMP_W'(req_first_y);
      bx      = CMP_W'(req_second_x);
      by      = CMP_W'(req_second_y);
      x_max   = CMP_W'(width_eff - SIDE_W'(1));
      y_max   = CMP_W'(length_eff - SIDE_W'(1));
      x0      = ax[CMP_W-1] ? '0 : ax;
      y0      = ay[CMP_W-1] ? '0 : ay;
      x1      = (bx > x_max) ? x_max : bx;
      y1      = (by > y_max) ? y_max : by;
      dx      = bx - ax;
      dy      = by - ay;
      adx     = dx[CMP_W-1] ? -dx : dx;
      ady     = dy[CMP_W-1] ? -dy : dy;
      outside = ax[CMP_W-1] || (ax > x_max) || ay[CMP_W-1] || (ay > y_max) ||
                bx[CMP_W-1] || (bx > x_max) || by[CMP_W-1] || (by > y_max);
   end

   // classify the item into a command for the back end
   always_comb begin
      cmd        = '0;
      cmd.kind   = CMD_REPORT;
      cmd.status = STATUS_OK;
      cmd.len    = length_eff;
      if (req_action == ACTION_PAINT) begin
         if ((bx < ax) || (by < ay)) begin
            cmd.status = STATUS_INVERTED;
         end else if ((x0 <= x1) && (y0 <= y1)) begin
            // an empty clipped rectangle just reports ok
            cmd.kind = CMD_PAINT;
            cmd.x_lo = COORD_W'(x0);
            cmd.x_hi = COORD_W'(x1);
            cmd.y_lo = COORD_W'(y0);
            cmd.y_hi = COORD_W'(y1);
         end
      end else if (outside) begin
         cmd.status = STATUS_OUTSIDE;
      end else begin
         cmd.kind  = CMD_LINE;
         cmd.x_lo  = COORD_W'(ax);
         cmd.y_lo  = COORD_W'(ay);
         cmd.x_hi  = COORD_W'(bx);
         cmd.y_hi  = COORD_W'(by);
         cmd.nx    = COORD_W'(adx);
         cmd.ny    = COORD_W'(ady);
         cmd.x_neg = !(dx > 0);
         cmd.y_neg = !(dy > 0);
      end
      // start cell address x * length + y
      base_prod = (ADDR_W + 1)'(cmd.x_lo) * (ADDR_W + 1)'(cmd.len);
      cmd.addr  = base_prod[ADDR_W-1:0] + ADDR_W'(cmd.y_lo);
   end

   // no intake while the grid is being cleared
   assign req_ready = !q_full && !clearing;
   assign q_push    = req_valid && req_ready;
   assign q_cmd     = cmd;

endmodule

FILE: hdl/ogl_back.sv
// back end: grid clearing, rectangle painting, line walking and result register
module ogl_back (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          clearing,
   input  logic                          q_not_empty,
   output logic                          q_pop,
   input  ogl_pkg::cmd_type              q_head,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ogl_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_collision,
   output logic [ogl_pkg::HIT_W-1:0]     rsp_last_hit_x,
   output logic [ogl_pkg::HIT_W-1:0]     rsp_last_hit_y
);

   import ogl_pkg::*;

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [COORD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [COORD_W-1:0]  ix_ff, ix_in, iy_ff, iy_in;
   logic [LHS_W-1:0]    lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in, row_ff, row_in;
   logic                hit_ff, hit_in;
   logic [COORD_W-1:0]  hx_ff, hx_in, hy_ff, hy_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [COORD_W-1:0]  tag_x_ff, tag_x_in, tag_y_ff, tag_y_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [HIT_W-1:0]    rsp_hx_ff, rsp_hx_in, rsp_hy_ff, rsp_hy_in;

   logic                walk_last, x_step, y_step;
   logic [ADDR_W-1:0]   x_off, y_off;
   logic                ram_we, ram_wdata, rsp_load;
   logic [0:0]          ram_rdata;

   // walk decisions
   assign walk_last = (ix_ff == cmd_ff.nx) && (iy_ff == cmd_ff.ny);
   assign x_step    = (lhs_ff <= rhs_ff);
   assign y_step    = (lhs_ff >= rhs_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == ADDR_W'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_not_empty) begin
               unique case (q_head.kind)
                  CMD_PAINT: state_in = ST_PAINT;
                  CMD_LINE:  state_in = ST_LINE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_PAINT: begin
            if ((py_ff == cmd_ff.y_hi) && (px_ff == cmd_ff.x_hi)) state_in = ST_DONE;
         end
         ST_LINE: begin
            if (walk_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      clearing   = (state_ff == ST_CLEAR);
      q_pop      = (state_ff == ST_IDLE) && q_not_empty;
      ram_we     = (state_ff == ST_CLEAR) || (state_ff == ST_PAINT);
      ram_wdata  = (state_ff == ST_PAINT);
      rd_pend_in = (state_ff == ST_LINE);
      rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // per-state datapath
   always_comb begin
      cmd_in   = cmd_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      ix_in    = ix_ff;
      iy_in    = iy_ff;
      lhs_in   = lhs_ff;
      rhs_in   = rhs_ff;
      addr_in  = addr_ff;
      row_in   = row_ff;
      hit_in   = hit_ff;
      hx_in    = hx_ff;
      hy_in    = hy_ff;
      tag_x_in = px_ff;
      tag_y_in = py_ff;
      x_off    = '0;
      y_off    = '0;
      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (q_not_empty) begin
               cmd_in  = q_head;
               px_in   = q_head.x_lo;
               py_in   = q_head.y_lo;
               ix_in   = '0;
               iy_in   = '0;
               lhs_in  = LHS_W'(q_head.ny);
               rhs_in  = LHS_W'(q_head.nx);
               addr_in = q_head.addr;
               row_in  = q_head.addr;
               hit_in  = 1'b0;
               hx_in   = '0;
               hy_in   = '0;
            end
         end
         ST_PAINT: begin
            // row-major sweep over the clipped rectangle
            if (py_ff == cmd_ff.y_hi) begin
               px_in   = px_ff + COORD_W'(1);
               py_in   = cmd_ff.y_lo;
               row_in  = row_ff + ADDR_W'(cmd_ff.len);
               addr_in = row_ff + ADDR_W'(cmd_ff.len);
            end else begin
               py_in   = py_ff + COORD_W'(1);
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         ST_LINE: begin
            // one cell per cycle; crossing products kept as running sums
            if (!walk_last) begin
               if (x_step) begin
                  x_off  = cmd_ff.x_neg ? ADDR_W'(0) - ADDR_W'(cmd_ff.len)
                                        : ADDR_W'(cmd_ff.len);
                  px_in  = cmd_ff.x_neg ? px_ff - COORD_W'(1) : px_ff + COORD_W'(1);
                  ix_in  = ix_ff + COORD_W'(1);
                  lhs_in = lhs_ff + LHS_W'({cmd_ff.ny, 1'b0});
               end
               if (y_step) begin
                  y_off  = cmd_ff.y_neg ? {ADDR_W{1'b1}} : ADDR_W'(1);
                  py_in  = cmd_ff.y_neg ? py_ff - COORD_W'(1) : py_ff + COORD_W'(1);
                  iy_in  = iy_ff + COORD_W'(1);
                  rhs_in = rhs_ff + LHS_W'({cmd_ff.nx, 1'b0});
               end
               addr_in = addr_ff + x_off + y_off;
            end
         end
         default: ;
      endcase
      // registered read data comes back in the cycle after its address
      if (rd_pend_ff && ram_rdata[0]) begin
         hit_in = 1'b1;
         hx_in  = tag_x_ff;
         hy_in  = tag_y_ff;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_hx_in     = rsp_hx_ff;
      rsp_hy_in     = rsp_hy_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd_ff.status;
         rsp_hit_in    = hit_ff;
         rsp_hx_in     = HIT_W'(hx_ff);
         rsp_hy_in     = HIT_W'(hy_ff);
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      ix_ff         <= ix_in;
      iy_ff         <= iy_in;
      lhs_ff        <= lhs_in;
      rhs_ff        <= rhs_in;
      row_ff        <= row_in;
      hit_ff        <= hit_in;
      hx_ff         <= hx_in;
      hy_ff         <= hy_in;
      tag_x_ff      <= tag_x_in;
      tag_y_ff      <= tag_y_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_hx_ff     <= rsp_hx_in;
      rsp_hy_ff     <= rsp_hy_in;
   end

   // occupancy bits, one per cell
   ogl_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_collision  = rsp_hit_ff;
   assign rsp_last_hit_x = rsp_hx_ff;
   assign rsp_last_hit_y = rsp_hy_ff;

endmodule

FILE: hdl/occupancy_grid_line_of_sight_core.sv
// Occupancy grid line-of-sight core: a one-bit-per-cell grid (cell x,y at
// address x*length+y) that paint requests mark as obstacle and line requests
// walk along the supercover line, reporting any obstacle and the last one met.
// After reset the grid is swept to free, one cell a cycle;
// req_ready stays low during that sweep while csr writes are still taken.
// The back end works the grid ram one cell per cycle: a paint visits each
// clipped cell, a line check each cell that it steps, and an item that is
// rejected or clips to nothing goes straight to the result register.
// A two-entry command queue lets the front classify the next request while
// the back is still working, and the result register lets the back finish
// while a result waits for rsp_ready.
module occupancy_grid_line_of_sight_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic signed [ogl_pkg::FIELD_W-1:0] req_first_x,
   input  logic signed [ogl_pkg::FIELD_W-1:0] req_first_y,
   input  logic signed [ogl_pkg::FIELD_W-1:0] req_second_x,
   input  logic signed [ogl_pkg::FIELD_W-1:0] req_second_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ogl_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_collision,
   output logic [ogl_pkg::HIT_W-1:0]          rsp_last_hit_x,
   output logic [ogl_pkg::HIT_W-1:0]          rsp_last_hit_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ogl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ogl_pkg::CFG_W-1:0]          csr_data
);

   import ogl_pkg::*;

   logic    q_full, q_push, q_pop, q_not_empty, clearing;
   cmd_type q_cmd, q_head;

   // request intake and classification
   ogl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_full       (q_full),
      .clearing     (clearing),
      .q_push       (q_push),
      .q_cmd        (q_cmd)
   );

   // command queue
   ogl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   // grid execution and result register
   ogl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .clearing       (clearing),
      .q_not_empty    (q_not_empty),
      .q_pop          (q_pop),
      .q_head         (q_head),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_collision  (rsp_collision),
      .rsp_last_hit_x (rsp_last_hit_x),
      .rsp_last_hit_y (rsp_last_hit_y)
   );

`ifndef SYNTHESIS
   // no transfer is taken while the grid sweep runs
   a_no_intake_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("request taken during grid clear");

   // queue never overflows
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   // back end only pops real commands
   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("command queue underflow");

   // rejected items never report a collision
   a_error_no_collision : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> !rsp_collision)
      else $error("collision flagged on an error result");
`endif

endmodule
